>>> src/wls_pkg.sv
// Shared constants, codes and interface types of the weighted level sampler.
package wls_pkg;

    // Book depth in levels and the widths that follow from it.
    localparam int MAX_LEVELS = 16;
    localparam int LVL_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
    // A sum of MAX_LEVELS words of 32 bits.
    localparam int TOT_W      = 32 + LVL_W;

    // Geometric weights: 1.0 in Q16 needs 17 bits, later weights stay below it.
    localparam int              W_W         = 17;
    localparam logic [W_W-1:0]  W_ONE       = 17'h10000;
    localparam logic [15:0]     DECAY_RESET = 16'd39750;

    // Item commands.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Event types.
    localparam logic [2:0] EV_ADD_BID    = 3'd0;
    localparam logic [2:0] EV_ADD_ASK    = 3'd1;
    localparam logic [2:0] EV_CANCEL_BID = 3'd2;
    localparam logic [2:0] EV_CANCEL_ASK = 3'd3;
    localparam logic [2:0] EV_EXEC_BUY   = 3'd4;
    localparam logic [2:0] EV_EXEC_SELL  = 3'd5;

    // Result side codes.
    localparam logic [1:0] SIDE_BID = 2'd0;
    localparam logic [1:0] SIDE_ASK = 2'd1;
    localparam logic [1:0] SIDE_NA  = 2'd2;

    // Write of one book level.
    typedef struct packed {
        logic             en;
        logic [LVL_W-1:0] addr;
        logic [31:0]      bid_price;
        logic [31:0]      ask_price;
        logic [31:0]      bid_depth;
        logic [31:0]      ask_depth;
    } book_wr_t;

    // Read of one book level on one side.
    typedef struct packed {
        logic [LVL_W-1:0] addr;
        logic             ask;
    } book_rd_t;

endpackage

>>> src/wls_book.sv
// Book copy: per-level bid and ask prices and depths, cleared by reset.
module wls_book (
    input  logic              clk,
    input  logic              rst_n,
    input  wls_pkg::book_wr_t wr,
    input  wls_pkg::book_rd_t depth_rd,
    input  wls_pkg::book_rd_t price_rd,
    output logic [31:0]       depth,
    output logic [31:0]       price
);
    import wls_pkg::*;

    logic [31:0] bid_price_reg [MAX_LEVELS];
    logic [31:0] ask_price_reg [MAX_LEVELS];
    logic [31:0] bid_depth_reg [MAX_LEVELS];
    logic [31:0] ask_depth_reg [MAX_LEVELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                bid_price_reg[i] <= '0;
                ask_price_reg[i] <= '0;
                bid_depth_reg[i] <= '0;
                ask_depth_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            bid_price_reg[wr.addr] <= wr.bid_price;
            ask_price_reg[wr.addr] <= wr.ask_price;
            bid_depth_reg[wr.addr] <= wr.bid_depth;
            ask_depth_reg[wr.addr] <= wr.ask_depth;
        end
    end

    assign depth = depth_rd.ask ? ask_depth_reg[depth_rd.addr] : bid_depth_reg[depth_rd.addr];
    assign price = price_rd.ask ? ask_price_reg[price_rd.addr] : bid_price_reg[price_rd.addr];

endmodule

>>> src/wls_mult.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
module wls_mult (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);
    import wls_pkg::*;

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= 64'(a) * 64'(b);
        end
    end

    assign p = p_reg;

endmodule

>>> src/weighted_level_sampler.sv
// Top level of the weighted level sampler: sequencer, book copy and shared multiplier.
//
// The block keeps a copy of an order book (bid and ask price and depth per level), written by
// load items, and answers each sample item with one result: side, price in ticks and chosen
// level. Add events pick a level with geometric weights r^k, where r is the Q0.16 decay_ratio
// register and each weight is the truncated product of the previous one and r; cancel events
// pick a level weighted by that side's depth; both use the first level whose cumulative
// weight exceeds u*total, with u the Q0.32 random fraction. Execute events return the best
// opposite price at level 0, and other event types return side "not applicable" and price 0.
// A load item is written to the book and produces no result. Execute and unknown events go
// straight to the finish step. Add and cancel events walk the n levels in use (up to 16 with
// a full book) twice through one shared multiplier, once to form the total and once to
// compare the running sum against the scaled threshold; the weight recurrence through the
// multiplier register sets the one-level-per-cycle pace.
// Degenerate samples (too few levels or a zero total) finish early at level 0. The block
// holds req_stall high while an item is in work; a finished result sits in the output
// register, so the next item is taken while the result still waits for rsp_stall to drop.
// The decay ratio is written through the cfg channel, which is always ready, and must only
// be changed while the block is idle.
module weighted_level_sampler (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        decay_ratio,

    input  logic               req_valid,
    output logic               req_stall,
    input  logic               cmd,
    input  logic [3:0]         level,
    input  logic signed [31:0] bid_price,
    input  logic signed [31:0] ask_price,
    input  logic [31:0]        bid_depth,
    input  logic [31:0]        ask_depth,
    input  logic [15:0]        book_levels,
    input  logic [2:0]         event_type,
    input  logic [31:0]        random_fraction,
    input  logic signed [31:0] best_bid,
    input  logic signed [31:0] best_ask,

    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         side,
    output logic signed [31:0] tick_price,
    output logic [3:0]         chosen_level
);
    import wls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM,
        S_THR_LO,
        S_THR_HI,
        S_THR_ADD,
        S_SCAN,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [15:0]        decay_reg, decay_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [LVL_W-1:0]   k_reg, k_next;
    logic [LVL_W-1:0]   lvl_reg, lvl_next;
    logic [31:0]        u_reg, u_next;
    logic               add_reg, add_next;
    logic [1:0]         side_reg, side_next;
    logic               use_table_reg, use_table_next;
    logic [31:0]        direct_reg, direct_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [TOT_W-1:0]   cum_reg, cum_next;
    logic [TOT_W-1:0]   thr_reg, thr_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [1:0]         side_out_reg, side_out_next;
    logic [31:0]        price_out_reg, price_out_next;
    logic [3:0]         level_out_reg, level_out_next;

    book_wr_t           book_wr;
    book_rd_t           depth_rd, price_rd;
    logic [31:0]        depth_q, price_q;

    logic               mult_en;
    logic [31:0]        mult_a, mult_b;
    logic [63:0]        prod;

    logic [W_W-1:0]     wt_add;
    logic [TOT_W-1:0]   wt_cur;
    logic [TOT_W-1:0]   sum_step;
    logic               last_lvl;
    logic [CNT_W-1:0]   n_in;
    logic               accept;

    wls_book u_book (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (book_wr),
        .depth_rd (depth_rd),
        .price_rd (price_rd),
        .depth    (depth_q),
        .price    (price_q)
    );

    wls_mult u_mult (
        .clk (clk),
        .en  (mult_en),
        .a   (mult_a),
        .b   (mult_b),
        .p   (prod)
    );

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);

    // Book writes happen at the edge that accepts a load item.
    always_comb
    begin
        book_wr.en        = accept && (cmd == CMD_LOAD) && (int'(level) < MAX_LEVELS);
        book_wr.addr      = LVL_W'(level);
        book_wr.bid_price = bid_price;
        book_wr.ask_price = ask_price;
        book_wr.bid_depth = bid_depth;
        book_wr.ask_depth = ask_depth;
    end

    // The depth walk follows the level counter; the price is read at the chosen level.
    assign depth_rd.addr = k_reg;
    assign depth_rd.ask  = (side_reg == SIDE_ASK);
    assign price_rd.addr = lvl_reg;
    assign price_rd.ask  = (side_reg == SIDE_ASK);

    // Level 0 of an add walk starts at 1.0; each later weight is the previous product
    // shifted down by 16, which the multiplier register delivers in the cycle after launch.
    assign wt_add   = (k_reg == '0) ? W_ONE : prod[W_W+15:16];
    assign wt_cur   = add_reg ? TOT_W'(wt_add) : TOT_W'(depth_q);
    assign last_lvl = (CNT_W'(k_reg) == (n_reg - CNT_W'(1)));
    assign sum_step = (state_reg == S_SCAN) ? (cum_reg + wt_cur) : (total_reg + wt_cur);
    assign n_in     = (book_levels > 16'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS)
                                                      : CNT_W'(book_levels);

    // Operand selection of the shared multiplier: weight recurrence during both walks,
    // the two halves of u*total while forming the threshold.
    always_comb
    begin
        mult_en = (state_reg != S_IDLE);
        unique case (state_reg)
            S_THR_LO:
            begin
                mult_a = u_reg;
                mult_b = total_reg[31:0];
            end
            S_THR_HI:
            begin
                mult_a = u_reg;
                mult_b = 32'(total_reg[TOT_W-1:32]);
            end
            default:
            begin
                mult_a = 32'(wt_add);
                mult_b = 32'(decay_reg);
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        decay_next     = decay_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        lvl_next       = lvl_reg;
        u_next         = u_reg;
        add_next       = add_reg;
        side_next      = side_reg;
        use_table_next = use_table_reg;
        direct_next    = direct_reg;
        total_next     = total_reg;
        cum_next       = cum_reg;
        thr_next       = thr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        side_out_next  = side_out_reg;
        price_out_next = price_out_reg;
        level_out_next = level_out_reg;

        if (cfg_valid && cfg_ready)
        begin
            decay_next = decay_ratio;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_SAMPLE))
                begin
                    n_next         = n_in;
                    u_next         = random_fraction;
                    k_next         = '0;
                    lvl_next       = '0;
                    total_next     = '0;
                    cum_next       = '0;
                    use_table_next = 1'b1;
                    direct_next    = '0;
                    state_next     = S_DONE;
                    unique case (event_type)
                        EV_ADD_BID, EV_ADD_ASK:
                        begin
                            add_next  = 1'b1;
                            side_next = (event_type == EV_ADD_ASK) ? SIDE_ASK : SIDE_BID;
                            // One level or none leaves no choice.
                            if (n_in > CNT_W'(1))
                            begin
                                state_next = S_SUM;
                            end
                        end
                        EV_CANCEL_BID, EV_CANCEL_ASK:
                        begin
                            add_next  = 1'b0;
                            side_next = (event_type == EV_CANCEL_ASK) ? SIDE_ASK : SIDE_BID;
                            if (n_in != '0)
                            begin
                                state_next = S_SUM;
                            end
                        end
                        EV_EXEC_BUY:
                        begin
                            side_next      = SIDE_ASK;
                            use_table_next = 1'b0;
                            direct_next    = best_ask;
                        end
                        EV_EXEC_SELL:
                        begin
                            side_next      = SIDE_BID;
                            use_table_next = 1'b0;
                            direct_next    = best_bid;
                        end
                        default:
                        begin
                            side_next      = SIDE_NA;
                            use_table_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SUM:
            begin
                total_next = sum_step;
                if (last_lvl)
                begin
                    // An empty side of the book falls back to level 0.
                    state_next = (sum_step == '0) ? S_DONE : S_THR_LO;
                end
                else
                begin
                    k_next = k_reg + LVL_W'(1);
                end
            end

            S_THR_LO:
            begin
                state_next = S_THR_HI;
            end

            S_THR_HI:
            begin
                // Upper half of u times the low word of the total.
                thr_next   = TOT_W'(prod[63:32]);
                state_next = S_THR_ADD;
            end

            S_THR_ADD:
            begin
                thr_next   = thr_reg + prod[TOT_W-1:0];
                k_next     = '0;
                state_next = S_SCAN;
            end

            S_SCAN:
            begin
                cum_next = sum_step;
                if ((thr_reg < sum_step) || last_lvl)
                begin
                    lvl_next   = k_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    k_next = k_reg + LVL_W'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    side_out_next  = side_reg;
                    price_out_next = use_table_reg ? price_q : direct_reg;
                    level_out_next = 4'(lvl_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            decay_reg     <= DECAY_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            decay_reg     <= decay_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        k_reg         <= k_next;
        lvl_reg       <= lvl_next;
        u_reg         <= u_next;
        add_reg       <= add_next;
        side_reg      <= side_next;
        use_table_reg <= use_table_next;
        direct_reg    <= direct_next;
        total_reg     <= total_next;
        cum_reg       <= cum_next;
        thr_reg       <= thr_next;
        side_out_reg  <= side_out_next;
        price_out_reg <= price_out_next;
        level_out_reg <= level_out_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign side         = side_out_reg;
    assign tick_price   = price_out_reg;
    assign chosen_level = level_out_reg;

    // The scaled threshold is u*total with u below one, so it stays under the total.
    a_thr_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (thr_reg < total_reg))
        else $error("threshold not below total during scan");

    // The walk never passes the last level of the book in use.
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SUM) || (state_reg == S_SCAN)) |-> (CNT_W'(k_reg) < n_reg))
        else $error("level walk beyond the book size");

    // A chosen level lies inside the book, or is the level 0 fallback.
    a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> ((CNT_W'(lvl_reg) < n_reg) || (lvl_reg == '0)))
        else $error("chosen level outside the book");

    // A new result appears only when a sample finishes.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the finish step");

endmodule

>>> bench/tb_weighted_level_sampler.sv
// Self-checking testbench for the weighted level sampler: random handshakes and a book predictor.
`timescale 1ns / 1ps

module tb_weighted_level_sampler;
    import wls_pkg::*;

    // Event types with no defined action. The block must answer them with side "not applicable".
    localparam logic [2:0] EV_SPARE_LO = 3'd6;
    localparam logic [2:0] EV_SPARE_HI = 3'd7;

    // The longest sample walks the full book of 16 levels twice. The settle time
    // before a register write, and at the end, gives that some margin.
    localparam int SETTLE_CYCLES = 48;
    // Cycles without any item moving on any channel before the run is declared hung.
    // A full walk, the longest stall and the longest gap together stay well below it.
    localparam int HANG_LIMIT    = 3000;
    localparam int PHASE_ITEMS   = 220;

    // One request item as the driver places it on the ports.
    typedef struct packed {
        logic        cmd;
        logic [3:0]  lvl;
        logic [31:0] bid_price;
        logic [31:0] ask_price;
        logic [31:0] bid_depth;
        logic [31:0] ask_depth;
        logic [15:0] book_levels;
        logic [2:0]  event_type;
        logic [31:0] random_fraction;
        logic [31:0] best_bid;
        logic [31:0] best_ask;
    } item_t;

    // One expected sample answer.
    typedef struct packed {
        logic [1:0]  side_code;
        logic [31:0] price;
        logic [3:0]  lvl;
    } pick_t;

    // Clock and reset. Reset is asserted once, at time zero.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always #2 clk = ~clk;

    // Every input of the block starts at a known value.
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [15:0]        decay_ratio     = '0;
    logic               req_valid       = 1'b0;
    logic               req_stall;
    logic               cmd             = 1'b0;
    logic [3:0]         level           = '0;
    logic signed [31:0] bid_price       = '0;
    logic signed [31:0] ask_price       = '0;
    logic [31:0]        bid_depth       = '0;
    logic [31:0]        ask_depth       = '0;
    logic [15:0]        book_levels     = '0;
    logic [2:0]         event_type      = '0;
    logic [31:0]        random_fraction = '0;
    logic signed [31:0] best_bid        = '0;
    logic signed [31:0] best_ask        = '0;
    logic               rsp_valid;
    logic               rsp_stall       = 1'b0;
    logic [1:0]         side;
    logic signed [31:0] tick_price;
    logic [3:0]         chosen_level;

    weighted_level_sampler u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .decay_ratio     (decay_ratio),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .cmd             (cmd),
        .level           (level),
        .bid_price       (bid_price),
        .ask_price       (ask_price),
        .bid_depth       (bid_depth),
        .ask_depth       (ask_depth),
        .book_levels     (book_levels),
        .event_type      (event_type),
        .random_fraction (random_fraction),
        .best_bid        (best_bid),
        .best_ask        (best_ask),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .side            (side),
        .tick_price      (tick_price),
        .chosen_level    (chosen_level)
    );

    // The testbench's own copy of the book and of the decay ratio. The book is updated
    // when a load item is accepted, the ratio when a register write is accepted.
    logic [31:0] bid_px_book [MAX_LEVELS];
    logic [31:0] ask_px_book [MAX_LEVELS];
    logic [31:0] bid_qty_book[MAX_LEVELS];
    logic [31:0] ask_qty_book[MAX_LEVELS];
    logic [15:0] ratio_now = DECAY_RESET;

    item_t stim_q[$];      // items waiting to be driven
    pick_t due_picks[$];   // sample answers the block still owes, oldest first

    int unsigned items_queued  = 0;
    int unsigned items_taken   = 0;
    int unsigned n_loads       = 0;
    int unsigned n_adds        = 0;
    int unsigned n_cancels     = 0;
    int unsigned n_execs       = 0;
    int unsigned n_other       = 0;
    int unsigned n_checked     = 0;
    int unsigned n_ratio_sets  = 0;
    int unsigned errors        = 0;
    int unsigned quiet_cycles  = 0;

    // Length of the next idle stretch for either side. Most stretches are zero or short,
    // a few are long, and now and then a calm run follows in which the side never idles.
    function automatic int unsigned idle_len(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(99);
        if (r == 0)
        begin
            calm = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Depths are drawn from several classes so that cancel picks see empty levels,
    // small and comparable levels, and levels large enough to dominate the total.
    function automatic logic [31:0] pick_depth();
        case ($urandom_range(4))
            0:       return '0;
            1:       return $urandom_range(1, 1000);
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Fields that a command does not use are still randomized, so that every port bit
    // toggles and the block is shown to ignore them.
    function automatic item_t make_load(logic [3:0] lvl, logic [31:0] bp, logic [31:0] ap,
                                        logic [31:0] bd, logic [31:0] ad);
        item_t it;
        it.cmd             = CMD_LOAD;
        it.lvl             = lvl;
        it.bid_price       = bp;
        it.ask_price       = ap;
        it.bid_depth       = bd;
        it.ask_depth       = ad;
        it.book_levels     = 16'($urandom);
        it.event_type      = 3'($urandom);
        it.random_fraction = $urandom;
        it.best_bid        = $urandom;
        it.best_ask        = $urandom;
        return it;
    endfunction

    function automatic item_t make_sample(logic [2:0] ev, logic [15:0] n, logic [31:0] u,
                                          logic [31:0] bb, logic [31:0] ba);
        item_t it;
        it.cmd             = CMD_SAMPLE;
        it.lvl             = 4'($urandom);
        it.bid_price       = $urandom;
        it.ask_price       = $urandom;
        it.bid_depth       = $urandom;
        it.ask_depth       = $urandom;
        it.book_levels     = n;
        it.event_type      = ev;
        it.random_fraction = u;
        it.best_bid        = bb;
        it.best_ask        = ba;
        return it;
    endfunction

    // Predicts the answer to one sample item from the current book and decay ratio.
    // Add events use geometric weights 1.0, r, r^2, ... in Q16 with each product truncated;
    // cancel events weight each level by that side's depth. The chosen level is the first
    // one whose running sum exceeds floor(u * total / 2^32), computed exactly at 72 bits.
    function automatic pick_t predict_sample(item_t it);
        bit [63:0]   wt[MAX_LEVELS];
        bit [63:0]   total;
        bit [63:0]   cum;
        bit [63:0]   thr;
        bit [71:0]   prod;
        int unsigned n;
        int unsigned pick;
        bit          weighted;
        bit          found;
        pick_t       res;

        n        = (it.book_levels > MAX_LEVELS) ? MAX_LEVELS : it.book_levels;
        pick     = 0;
        weighted = 1'b0;
        found    = 1'b0;

        // Fewer than two levels leaves an add event nothing to choose from.
        if ((it.event_type == EV_ADD_BID || it.event_type == EV_ADD_ASK) && n > 1)
        begin
            wt[0] = 64'(W_ONE);
            for (int k = 1; k < n; k++)
                wt[k] = (wt[k-1] * ratio_now) >> 16;
            weighted = 1'b1;
        end
        if ((it.event_type == EV_CANCEL_BID || it.event_type == EV_CANCEL_ASK) && n > 0)
        begin
            for (int k = 0; k < n; k++)
                wt[k] = (it.event_type == EV_CANCEL_BID) ? bid_qty_book[k] : ask_qty_book[k];
            weighted = 1'b1;
        end

        if (weighted)
        begin
            total = '0;
            for (int k = 0; k < n; k++)
                total += wt[k];
            // An empty book side (zero total) falls back to the top level.
            if (total != 0)
            begin
                prod = total * it.random_fraction;
                thr  = prod[71:32];
                cum  = '0;
                for (int k = 0; k < n; k++)
                begin
                    if (!found)
                    begin
                        cum += wt[k];
                        if (thr < cum)
                        begin
                            pick  = k;
                            found = 1'b1;
                        end
                    end
                end
                // Cannot happen with a nonzero total, kept to mirror the selection rule.
                if (!found)
                    pick = n - 1;
            end
        end

        case (it.event_type)
            EV_ADD_BID, EV_CANCEL_BID: res = '{SIDE_BID, bid_px_book[pick], pick[3:0]};
            EV_ADD_ASK, EV_CANCEL_ASK: res = '{SIDE_ASK, ask_px_book[pick], pick[3:0]};
            EV_EXEC_BUY:               res = '{SIDE_ASK, it.best_ask, 4'd0};
            EV_EXEC_SELL:              res = '{SIDE_BID, it.best_bid, 4'd0};
            default:                   res = '{SIDE_NA, 32'd0, 4'd0};
        endcase
        return res;
    endfunction

    // Request driver. An item is taken at an edge where valid is high and stall is low.
    // At that edge the item updates the book copy or queues its predicted answer, and the
    // next item (or an idle gap) is placed on the ports. A stalled item is left untouched.
    item_t       on_bus;
    int unsigned hold_off  = 0;
    int unsigned drv_calm  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            hold_off = 0;
            for (int k = 0; k < MAX_LEVELS; k++)
            begin
                bid_px_book[k]  = '0;
                ask_px_book[k]  = '0;
                bid_qty_book[k] = '0;
                ask_qty_book[k] = '0;
            end
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                if (on_bus.cmd == CMD_LOAD)
                begin
                    // Indexes past the book are ignored by the block.
                    if (on_bus.lvl < MAX_LEVELS)
                    begin
                        bid_px_book[on_bus.lvl]  = on_bus.bid_price;
                        ask_px_book[on_bus.lvl]  = on_bus.ask_price;
                        bid_qty_book[on_bus.lvl] = on_bus.bid_depth;
                        ask_qty_book[on_bus.lvl] = on_bus.ask_depth;
                    end
                    n_loads++;
                end
                else
                begin
                    due_picks.push_back(predict_sample(on_bus));
                    if (on_bus.event_type inside {EV_ADD_BID, EV_ADD_ASK})
                        n_adds++;
                    else if (on_bus.event_type inside {EV_CANCEL_BID, EV_CANCEL_ASK})
                        n_cancels++;
                    else if (on_bus.event_type inside {EV_EXEC_BUY, EV_EXEC_SELL})
                        n_execs++;
                    else
                        n_other++;
                end
                items_taken++;
            end

            if (!req_valid || !req_stall)
            begin
                if (hold_off > 0)
                begin
                    hold_off--;
                    req_valid <= 1'b0;
                end
                else if (stim_q.size() > 0)
                begin
                    on_bus = stim_q.pop_front();
                    cmd             <= on_bus.cmd;
                    level           <= on_bus.lvl;
                    bid_price       <= on_bus.bid_price;
                    ask_price       <= on_bus.ask_price;
                    bid_depth       <= on_bus.bid_depth;
                    ask_depth       <= on_bus.ask_depth;
                    book_levels     <= on_bus.book_levels;
                    event_type      <= on_bus.event_type;
                    random_fraction <= on_bus.random_fraction;
                    best_bid        <= on_bus.best_bid;
                    best_ask        <= on_bus.best_ask;
                    req_valid       <= 1'b1;
                    hold_off = idle_len(drv_calm);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern. Each answer taken at an edge is compared
    // field by field with the oldest prediction; the stall for the next edge is set here too.
    int unsigned stall_left = 0;
    int unsigned mon_calm   = 0;
    pick_t       want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (due_picks.size() == 0)
                begin
                    $error("unexpected result: side %0d tick_price %0d chosen_level %0d",
                           side, tick_price, chosen_level);
                    errors++;
                end
                else
                begin
                    want = due_picks.pop_front();
                    if (side !== want.side_code)
                    begin
                        $error("side: expected %0d, actual %0d", want.side_code, side);
                        errors++;
                    end
                    if (tick_price !== want.price)
                    begin
                        $error("tick_price: expected %0d, actual %0d",
                               $signed(want.price), tick_price);
                        errors++;
                    end
                    if (chosen_level !== want.lvl)
                    begin
                        $error("chosen_level: expected %0d, actual %0d", want.lvl, chosen_level);
                        errors++;
                    end
                    n_checked++;
                end
            end

            if (stall_left == 0 && $urandom_range(3) == 0)
                stall_left = idle_len(mon_calm);
            rsp_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // Hang detection: any item moving on any channel restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("hang: %0d items taken of %0d, %0d answers outstanding",
                         items_taken, items_queued, due_picks.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Writes the decay ratio. Only called while the block is idle.
    task automatic write_decay(input logic [15:0] value);
        @(posedge clk);
        cfg_valid   <= 1'b1;
        decay_ratio <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ratio_now = value;
        n_ratio_sets++;
    endtask

    // Returns once every queued item has been taken and every answer has arrived, plus
    // enough cycles for a trailing load or a late sample to drain out of the block.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (items_taken != items_queued || due_picks.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_item(input item_t it);
        stim_q.push_back(it);
        items_queued++;
    endtask

    // The settings walked through after the directed part: both extremes of the ratio,
    // the smallest nonzero one, one half, the reset value again and two random ones.
    logic [15:0] ratio_plan[7];

    initial
    begin
        logic [2:0]  ev;
        logic [15:0] n;
        logic [31:0] u;

        ratio_plan = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h0000, DECAY_RESET, 16'h0000};
        ratio_plan[4] = 16'($urandom);
        ratio_plan[6] = 16'($urandom);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, at the reset ratio. The book is still empty for the first two
        // samples: a cancel on an empty side falls back to level 0, and prices read as 0.
        queue_item(make_sample(EV_CANCEL_BID, 16'd16, 32'hFFFF_FFFF, $urandom, $urandom));
        queue_item(make_sample(EV_ADD_ASK, 16'd16, 32'hFFFF_FFFF, $urandom, $urandom));
        // Price and depth extremes at the top, bottom and middle of the book.
        queue_item(make_load(4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0));
        queue_item(make_load(4'd15, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF));
        queue_item(make_load(4'd7, -32'sd5, 32'd12345, 32'd1000, 32'd1000));
        // Add events with no level, one level, two levels, a full book and a clamped count.
        queue_item(make_sample(EV_ADD_BID, 16'd0, 32'hFFFF_FFFF, $urandom, $urandom));
        queue_item(make_sample(EV_ADD_ASK, 16'd1, 32'hFFFF_FFFF, $urandom, $urandom));
        queue_item(make_sample(EV_ADD_BID, 16'd2, 32'd0, $urandom, $urandom));
        queue_item(make_sample(EV_ADD_BID, 16'd16, 32'hFFFF_FFFF, $urandom, $urandom));
        queue_item(make_sample(EV_ADD_ASK, 16'hFFFF, 32'hFFFF_FFFF, $urandom, $urandom));
        queue_item(make_sample(EV_ADD_BID, 16'd17, 32'h8000_0000, $urandom, $urandom));
        // Cancel events: no level, skipping empty levels, the deepest level, and a range
        // of levels whose ask depth is all zero.
        queue_item(make_sample(EV_CANCEL_BID, 16'd0, 32'hFFFF_FFFF, $urandom, $urandom));
        queue_item(make_sample(EV_CANCEL_ASK, 16'd16, 32'd0, $urandom, $urandom));
        queue_item(make_sample(EV_CANCEL_ASK, 16'd16, 32'hFFFF_FFFF, $urandom, $urandom));
        queue_item(make_sample(EV_CANCEL_BID, 16'd16, 32'h8000_0000, $urandom, $urandom));
        queue_item(make_sample(EV_CANCEL_ASK, 16'd7, 32'hFFFF_FFFF, $urandom, $urandom));
        // Execute events with both price extremes, and the two undefined event types.
        queue_item(make_sample(EV_EXEC_BUY, 16'($urandom), $urandom,
                               32'h8000_0000, 32'h7FFF_FFFF));
        queue_item(make_sample(EV_EXEC_SELL, 16'($urandom), $urandom,
                               32'h8000_0000, 32'h7FFF_FFFF));
        queue_item(make_sample(EV_EXEC_BUY, 16'($urandom), $urandom,
                               32'h7FFF_FFFF, 32'h8000_0000));
        queue_item(make_sample(EV_EXEC_SELL, 16'($urandom), $urandom,
                               32'h7FFF_FFFF, 32'h8000_0000));
        queue_item(make_sample(EV_SPARE_LO, 16'($urandom), $urandom, $urandom, $urandom));
        queue_item(make_sample(EV_SPARE_HI, 16'($urandom), $urandom, $urandom, $urandom));
        wait_idle();

        // Random part, one phase per ratio setting. About a third of the items are loads so
        // the book keeps changing; samples lean toward add and cancel, which exercise the walk.
        foreach (ratio_plan[p])
        begin
            write_decay(ratio_plan[p]);
            @(negedge clk);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 35)
                begin
                    queue_item(make_load(4'($urandom), $urandom, $urandom,
                                         pick_depth(), pick_depth()));
                end
                else
                begin
                    ev = 3'(($urandom_range(9) < 6) ? $urandom_range(3) : $urandom_range(4, 7));
                    case ($urandom_range(9))
                        0:       n = 16'($urandom_range(1));
                        1:       n = ($urandom_range(1) == 0) ? 16'hFFFF
                                                              : 16'($urandom_range(17, 65535));
                        default: n = 16'($urandom_range(2, 16));
                    endcase
                    case ($urandom_range(9))
                        0:       u = '0;
                        1:       u = 32'hFFFF_FFFF;
                        default: u = $urandom;
                    endcase
                    queue_item(make_sample(ev, n, u, $urandom, $urandom));
                end
            end
            wait_idle();
        end

        $display("Covered %0d book loads and %0d samples: %0d add, %0d cancel, %0d execute,",
                 n_loads, n_adds + n_cancels + n_execs + n_other, n_adds, n_cancels, n_execs);
        $display("%0d other; checked %0d answers over %0d decay ratio writes, %0d mismatches.",
                 n_other, n_checked, n_ratio_sets, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
